>>> hdl/dtq_pkg.sv
// Package with the types and constants of the deadline timer queue.
`timescale 1ns / 1ps
package dtq_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS = 8;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ACT_TICK = 3'd0;
    localparam logic [2:0] ACT_REQUEST = 3'd1;
    localparam logic [2:0] ACT_CANCEL = 3'd2;
    localparam logic [2:0] ACT_START = 3'd3;
    localparam logic [2:0] ACT_STOP = 3'd4;
    localparam logic [2:0] ACT_READ = 3'd5;

    localparam logic [3:0] ST_ACCEPTED = 4'd0;
    localparam logic [3:0] ST_PAST = 4'd1;
    localparam logic [3:0] ST_STALE = 4'd2;
    localparam logic [3:0] ST_FIRED = 4'd3;
    localparam logic [3:0] ST_CANCELLED = 4'd4;
    localparam logic [3:0] ST_NOT_PENDING = 4'd5;
    localparam logic [3:0] ST_NOT_STARTED = 4'd6;
    localparam logic [3:0] ST_FULL = 4'd7;
    localparam logic [3:0] ST_DUPLICATE = 4'd8;
    localparam logic [3:0] ST_TIME_READ = 4'd9;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  request_id;
        logic [31:0] delay_ticks;
        logic [63:0] absolute_deadline;
        logic [7:0]  request_revision;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  result_id;
        logic [63:0] time_now;
        logic        counter_running;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic               ins;
        logic               del;
        logic [63:0]        dl;
        logic [ID_BITS-1:0] id;
    } t_cell_cmd;
endpackage

>>> hdl/dtq_cell.sv
// One cell of the sorted chain: holds one entry and shifts on insert or removal.
`timescale 1ns / 1ps
module dtq_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtq_pkg::t_cell_cmd            i_cmd,
    input  logic                          i_prev_valid,
    input  logic                          i_prev_le,
    input  logic                          i_prev_hit,
    input  logic [63:0]                   i_prev_dl,
    input  logic [dtq_pkg::ID_BITS-1:0]   i_prev_id,
    input  logic                          i_next_valid,
    input  logic [63:0]                   i_next_dl,
    input  logic [dtq_pkg::ID_BITS-1:0]   i_next_id,
    output logic                          o_valid,
    output logic                          o_le,
    output logic                          o_hit,
    output logic [63:0]                   o_dl,
    output logic [dtq_pkg::ID_BITS-1:0]   o_id
);
    import dtq_pkg::*;
    logic r_valid;
    logic [63:0] r_dl;
    logic [ID_BITS-1:0] r_id;
    logic le;
    logic hit_here;

    assign le = r_valid && (r_dl <= i_cmd.dl);
    assign hit_here = r_valid && (r_id == i_cmd.id) && !i_prev_hit;
    assign o_le = le;
    assign o_hit = i_prev_hit || hit_here;
    assign o_valid = r_valid;
    assign o_dl = r_dl;
    assign o_id = r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins) begin
            if (!le) begin
                r_valid <= i_prev_valid || r_valid || i_prev_le;
                if (i_prev_le) begin
                    r_dl <= i_cmd.dl;
                    r_id <= i_cmd.id;
                end else begin
                    r_dl <= i_prev_dl;
                    r_id <= i_prev_id;
                end
            end
        end else if (i_cmd.del && o_hit) begin
            r_valid <= i_next_valid;
            r_dl <= i_next_dl;
            r_id <= i_next_id;
        end
    end
endmodule

>>> hdl/deadline_timer_queue_core.sv
// Top level of the deadline timer queue: control, time count and cell chain.
//   channel | signals                        | handshake
//   item in | i_start, o_busy, i_item        | taken when i_start and !o_busy
//   result  | o_res_stb, o_res               | one cycle per strobe, no stall
//   config  | i_cfg_we, i_cfg_data           | written when i_cfg_we
// A request, cancel, start, stop or read passes through S_EXEC and gives one result.
// A tick moves to S_FIRE, which gives one result per fired entry (up to the depth),
// since each firing pops the chain head; it returns to idle once it finds nothing due.
// Reset clears the chain.
// Results cannot be stalled; o_busy holds off new items until work is done.
`timescale 1ns / 1ps
module deadline_timer_queue_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  dtq_pkg::t_in_item i_item,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data,
    output logic              o_res_stb,
    output dtq_pkg::t_out_item o_res
);
    import dtq_pkg::*;
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIRE} t_state;

    t_state r_state;
    t_in_item r_item;
    logic [7:0] r_rev, r_users;
    logic [63:0] r_time;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_nfire;
    t_cell_cmd cmd;

    logic [QUEUE_DEPTH:0] v_ch, le_ch, hit_ch;
    logic [63:0] dl_ch [QUEUE_DEPTH+1];
    logic [ID_BITS-1:0] id_ch [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH:0] nv_ch;
    logic [63:0] ndl_ch [QUEUE_DEPTH+1];
    logic [ID_BITS-1:0] nid_ch [QUEUE_DEPTH+1];

    logic [63:0] req_dl;
    logic [ID_BITS-1:0] in_id;
    logic running, head_due, dup, found;
    logic tail_late;
    logic [3:0] req_st;

    assign in_id = r_item.request_id[ID_BITS-1:0];
    assign req_dl = (r_item.delay_ticks != 32'd0)
        ? r_time + {32'd0, r_item.delay_ticks} : r_item.absolute_deadline;
    assign running = (r_users != 8'd0) || (r_fill != '0);
    assign head_due = v_ch[1] && (dl_ch[1] <= r_time);
    assign found = hit_ch[QUEUE_DEPTH];
    assign dup = found;
    // The tail holds the latest deadline, so entries survive the tick only if it is not due.
    assign tail_late = (r_fill != '0) && (dl_ch[r_fill] > r_time);

    always_comb begin
        if (r_item.request_revision != 8'd0 && r_item.request_revision != r_rev)
            req_st = ST_STALE;
        else if (req_dl <= r_time)
            req_st = ST_PAST;
        else if (r_fill == CNT_W'(QUEUE_DEPTH))
            req_st = ST_FULL;
        else if (dup)
            req_st = ST_DUPLICATE;
        else
            req_st = ST_ACCEPTED;
    end

    always_comb begin
        cmd.ins = 1'b0;
        cmd.del = 1'b0;
        cmd.dl = req_dl;
        cmd.id = in_id;
        if (r_state == S_EXEC && r_item.action == ACT_REQUEST && req_st == ST_ACCEPTED)
            cmd.ins = 1'b1;
        if (r_state == S_EXEC && r_item.action == ACT_CANCEL && found)
            cmd.del = 1'b1;
        if (r_state == S_FIRE && head_due && r_nfire != CNT_W'(QUEUE_DEPTH)) begin
            cmd.del = 1'b1;
            cmd.id = id_ch[1];
        end
    end

    assign v_ch[0] = 1'b0;
    assign le_ch[0] = 1'b1;
    assign hit_ch[0] = 1'b0;
    assign dl_ch[0] = '0;
    assign id_ch[0] = '0;
    assign nv_ch[QUEUE_DEPTH] = 1'b0;
    assign ndl_ch[QUEUE_DEPTH] = '0;
    assign nid_ch[QUEUE_DEPTH] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        dtq_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
            .i_prev_valid(v_ch[g]), .i_prev_le(le_ch[g]), .i_prev_hit(hit_ch[g]),
            .i_prev_dl(dl_ch[g]), .i_prev_id(id_ch[g]),
            .i_next_valid(nv_ch[g+1]), .i_next_dl(ndl_ch[g+1]),
            .i_next_id(nid_ch[g+1]),
            .o_valid(v_ch[g+1]), .o_le(le_ch[g+1]), .o_hit(hit_ch[g+1]),
            .o_dl(dl_ch[g+1]), .o_id(id_ch[g+1])
        );
        assign nv_ch[g] = v_ch[g+1];
        assign ndl_ch[g] = dl_ch[g+1];
        assign nid_ch[g] = id_ch[g+1];
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rev <= 8'd1;
            r_users <= 8'd0;
            r_time <= '0;
            r_fill <= '0;
            r_nfire <= '0;
            o_res_stb <= 1'b0;
        end else begin
            o_res_stb <= 1'b0;
            if (i_cfg_we)
                r_rev <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_item <= i_item;
                        if (i_item.action == ACT_TICK) begin
                            r_state <= S_FIRE;
                            r_nfire <= '0;
                            if (running)
                                r_time <= r_time + 64'd1;
                        end else if (i_item.action <= ACT_READ) begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    o_res_stb <= 1'b1;
                    o_res.result_id <= r_item.request_id;
                    o_res.time_now <= r_time;
                    o_res.last <= 1'b1;
                    o_res.counter_running <= running;
                    case (r_item.action)
                        ACT_REQUEST: begin
                            o_res.status <= req_st;
                            if (req_st == ST_ACCEPTED) begin
                                r_fill <= r_fill + 1'b1;
                                o_res.counter_running <= 1'b1;
                            end
                        end
                        ACT_CANCEL: begin
                            if (found) begin
                                o_res.status <= ST_CANCELLED;
                                r_fill <= r_fill - 1'b1;
                                o_res.counter_running <= (r_users != 8'd0)
                                    || (r_fill != CNT_W'(1));
                            end else begin
                                o_res.status <= ST_NOT_PENDING;
                            end
                        end
                        ACT_START: begin
                            o_res.status <= ST_ACCEPTED;
                            if (r_users != 8'hff)
                                r_users <= r_users + 8'd1;
                            o_res.counter_running <= 1'b1;
                        end
                        ACT_STOP: begin
                            if (r_users == 8'd0) begin
                                o_res.status <= ST_NOT_STARTED;
                            end else begin
                                o_res.status <= ST_ACCEPTED;
                                r_users <= r_users - 8'd1;
                                o_res.counter_running <= (r_users != 8'd1)
                                    || (r_fill != '0);
                            end
                        end
                        default: begin
                            o_res.status <= ST_TIME_READ;
                        end
                    endcase
                end
                S_FIRE: begin
                    if (cmd.del) begin
                        o_res_stb <= 1'b1;
                        o_res.status <= ST_FIRED;
                        o_res.result_id <= 8'(id_ch[1]);
                        o_res.time_now <= r_time;
                        o_res.counter_running <= (r_users != 8'd0) || tail_late;
                        o_res.last <= !(v_ch[2] && dl_ch[2] <= r_time)
                            || (r_nfire == CNT_W'(QUEUE_DEPTH - 1));
                        r_fill <= r_fill - 1'b1;
                        r_nfire <= r_nfire + 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> tb/tb.sv
// Self-checking testbench for the deadline timer queue core.
`timescale 1ns / 1ps
module tb;
    import dtq_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        bit         chk;
        logic [3:0] st;
    } t_typed;

    typedef struct {
        t_in_item   it;
        bit         chk;
        logic [3:0] st;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_start = 1'b0;
    logic      o_busy;
    t_in_item  i_item = '0;
    logic      i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;
    logic      o_res_stb;
    t_out_item o_res;

    // Mirror of the block's state.
    logic [63:0] sim_time;
    logic [63:0] sim_dl[QUEUE_DEPTH];
    logic [7:0]  sim_id[QUEUE_DEPTH];
    int          sim_fill;
    logic [7:0]  sim_users;
    logic [7:0]  sim_rev;

    t_out_item expected_results[$];
    t_typed    typed_status[$];
    int        errors = 0;
    int        quiet_cycles = 0;
    int        idle_pct = 0;

    deadline_timer_queue_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .o_busy    (o_busy),
        .i_item    (i_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_res_stb (o_res_stb),
        .o_res     (o_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int find_pending(logic [7:0] id);
        for (int i = 0; i < sim_fill; i++) begin
            if (sim_id[i] == id) return i;
        end
        return -1;
    endfunction

    task automatic drop_entry(int p);
        for (int j = p; j + 1 < sim_fill; j++) begin
            sim_dl[j] = sim_dl[j + 1];
            sim_id[j] = sim_id[j + 1];
        end
        sim_fill--;
    endtask

    task automatic predict_timer(t_in_item it);
        logic [3:0]  st[$];
        logic [7:0]  ids[$];
        logic [63:0] dl;
        int          pos;
        t_out_item   r;
        case (it.action)
            ACT_TICK: begin
                if (sim_users != 0 || sim_fill != 0) sim_time = sim_time + 64'd1;
                while (sim_fill > 0 && st.size() < 16 && sim_dl[0] <= sim_time) begin
                    st.push_back(ST_FIRED);
                    ids.push_back(sim_id[0]);
                    drop_entry(0);
                end
            end
            ACT_REQUEST: begin
                dl = (it.delay_ticks != 0) ? sim_time + {32'd0, it.delay_ticks}
                                           : it.absolute_deadline;
                ids.push_back(it.request_id);
                if (it.request_revision != 0 && it.request_revision != sim_rev)
                    st.push_back(ST_STALE);
                else if (dl <= sim_time) st.push_back(ST_PAST);
                else if (sim_fill >= QUEUE_DEPTH) st.push_back(ST_FULL);
                else if (find_pending(it.request_id) >= 0) st.push_back(ST_DUPLICATE);
                else begin
                    pos = 0;
                    while (pos < sim_fill && sim_dl[pos] <= dl) pos++;
                    for (int j = sim_fill; j > pos; j--) begin
                        sim_dl[j] = sim_dl[j - 1];
                        sim_id[j] = sim_id[j - 1];
                    end
                    sim_dl[pos] = dl;
                    sim_id[pos] = it.request_id;
                    sim_fill++;
                    st.push_back(ST_ACCEPTED);
                end
            end
            ACT_CANCEL: begin
                pos = find_pending(it.request_id);
                ids.push_back(it.request_id);
                if (pos >= 0) begin
                    drop_entry(pos);
                    st.push_back(ST_CANCELLED);
                end else st.push_back(ST_NOT_PENDING);
            end
            ACT_START: begin
                if (sim_users != 8'hff) sim_users++;
                ids.push_back(it.request_id);
                st.push_back(ST_ACCEPTED);
            end
            ACT_STOP: begin
                ids.push_back(it.request_id);
                if (sim_users == 0) st.push_back(ST_NOT_STARTED);
                else begin
                    sim_users--;
                    st.push_back(ST_ACCEPTED);
                end
            end
            ACT_READ: begin
                ids.push_back(it.request_id);
                st.push_back(ST_TIME_READ);
            end
            default: ;
        endcase
        for (int k = 0; k < st.size(); k++) begin
            r.status = st[k];
            r.result_id = ids[k];
            r.time_now = sim_time;
            r.counter_running = (sim_users != 0 || sim_fill != 0);
            r.last = (k == st.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        t_typed    t;
        bit        active;
        active = 1'b0;
        if (!i_rst_n) begin
            sim_time = '0;
            sim_fill = 0;
            sim_users = '0;
            sim_rev = 8'd1;
        end else begin
            if (i_cfg_we) sim_rev = i_cfg_data;
            if (o_res_stb) begin
                active = 1'b1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d id %0d", o_res.status,
                           o_res.result_id);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_res.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, o_res.status);
                        errors++;
                    end
                    if (o_res.result_id !== e.result_id) begin
                        $error("result_id: expected %0d, got %0d", e.result_id,
                               o_res.result_id);
                        errors++;
                    end
                    if (o_res.time_now !== e.time_now) begin
                        $error("time_now: expected %0h, got %0h", e.time_now,
                               o_res.time_now);
                        errors++;
                    end
                    if (o_res.counter_running !== e.counter_running) begin
                        $error("counter_running: expected %0b, got %0b",
                               e.counter_running, o_res.counter_running);
                        errors++;
                    end
                    if (o_res.last !== e.last) begin
                        $error("last: expected %0b, got %0b", e.last, o_res.last);
                        errors++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                active = 1'b1;
                t = typed_status.pop_front();
                predict_timer(i_item);
                if (t.chk) expected_results[$].status = t.st;
            end
        end
        quiet_cycles = active ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("deadline_timer_queue_core verification failed");
            $finish;
        end
    end

    task automatic send_item(t_in_item it, bit chk = 1'b0, logic [3:0] st = ST_ACCEPTED);
        t_typed t;
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        t.chk = chk;
        t.st = st;
        typed_status.push_back(t);
        i_start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic write_revision(logic [7:0] v);
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(logic [2:0] act, logic [7:0] id,
                                           logic [31:0] dly, logic [63:0] abs_dl,
                                           logic [7:0] rrev);
        t_in_item it;
        it.action = act;
        it.request_id = id;
        it.delay_ticks = dly;
        it.absolute_deadline = abs_dl;
        it.request_revision = rrev;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       w;
        it = make_item(ACT_TICK, 8'($urandom), $urandom, {$urandom, $urandom}, 8'($urandom));
        w = $urandom_range(99);
        if (w < 40) it.action = ACT_TICK;
        else if (w < 72) begin
            it.action = ACT_REQUEST;
            if ($urandom_range(3) != 0) it.request_id = 8'($urandom_range(19));
            w = $urandom_range(9);
            if (w < 6) it.delay_ticks = $urandom_range(1, 25);
            else if (w < 8) begin
                it.delay_ticks = 0;
                it.absolute_deadline = sim_time + 64'($urandom_range(0, 30)) - 64'd3;
            end else if (w == 8) it.delay_ticks = 0;
            w = $urandom_range(9);
            if (w < 6) it.request_revision = 8'd0;
            else if (w < 9) it.request_revision = sim_rev;
        end else if (w < 84) begin
            it.action = ACT_CANCEL;
            if ($urandom_range(3) != 0) it.request_id = 8'($urandom_range(19));
        end else if (w < 89) it.action = ACT_START;
        else if (w < 94) it.action = ACT_STOP;
        else if (w < 98) it.action = ACT_READ;
        else it.action = 3'($urandom_range(6, 7));
        return it;
    endfunction

    task automatic random_phase(int n);
        int base;
        int sent;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(19) == 0) begin
                base = $urandom_range(200);
                for (int j = 0; j < QUEUE_DEPTH + 1; j++)
                    send_item(make_item(ACT_REQUEST, 8'(base + j), 32'd1, '0, 8'd0));
                send_item(make_item(ACT_TICK, '0, '0, '0, '0));
                sent += QUEUE_DEPTH + 2;
            end else begin
                send_item(random_item());
                sent++;
            end
        end
    endtask

    t_row directed[$];

    initial begin
        directed = '{
            '{make_item(ACT_READ, 8'd0, 0, 0, 0), 1, ST_TIME_READ},
            '{make_item(ACT_STOP, 8'd1, 0, 0, 0), 1, ST_NOT_STARTED},
            '{make_item(ACT_REQUEST, 8'd2, 5, 0, 8'd2), 1, ST_STALE},
            '{make_item(ACT_REQUEST, 8'd3, 0, 0, 0), 1, ST_PAST},
            '{make_item(ACT_REQUEST, 8'd5, 32'hffffffff, 0, 0), 0, ST_ACCEPTED},
            '{make_item(ACT_REQUEST, 8'd5, 3, 0, 0), 1, ST_DUPLICATE},
            '{make_item(ACT_REQUEST, 8'd6, 3, 0, 8'd1), 0, ST_ACCEPTED},
            '{make_item(ACT_REQUEST, 8'd7, 3, 0, 0), 0, ST_ACCEPTED},
            '{make_item(ACT_CANCEL, 8'd200, 0, 0, 0), 1, ST_NOT_PENDING},
            '{make_item(ACT_CANCEL, 8'd5, 0, 0, 0), 1, ST_CANCELLED},
            '{make_item(ACT_TICK, 0, 0, 0, 0), 0, ST_ACCEPTED},
            '{make_item(ACT_TICK, 0, 0, 0, 0), 0, ST_ACCEPTED},
            '{make_item(ACT_TICK, 0, 0, 0, 0), 0, ST_ACCEPTED},
            '{make_item(ACT_START, 8'd9, 0, 0, 0), 1, ST_ACCEPTED},
            '{make_item(ACT_START, 8'd10, 0, 0, 0), 1, ST_ACCEPTED},
            '{make_item(ACT_TICK, 0, 0, 0, 0), 0, ST_ACCEPTED},
            '{make_item(ACT_STOP, 8'd11, 0, 0, 0), 1, ST_ACCEPTED},
            '{make_item(ACT_STOP, 8'd12, 0, 0, 0), 1, ST_ACCEPTED},
            '{make_item(3'd6, 8'hff, 32'hffffffff, '1, 8'hff), 0, ST_ACCEPTED},
            '{make_item(3'd7, 0, 0, 0, 0), 0, ST_ACCEPTED},
            '{make_item(ACT_TICK, 0, 0, 0, 0), 0, ST_ACCEPTED},
            '{make_item(ACT_REQUEST, 8'hff, 0, 64'hffffffff00000000, 8'hff), 1, ST_STALE},
            '{make_item(ACT_REQUEST, 8'hff, 0, 64'hffffffffffffffff, 0), 0, ST_ACCEPTED},
            '{make_item(ACT_CANCEL, 8'hff, 0, 0, 0), 1, ST_CANCELLED}
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        foreach (directed[i]) send_item(directed[i].it, directed[i].chk, directed[i].st);

        write_revision(8'd0);
        idle_pct = 15;
        random_phase(22);
        write_revision(8'hff);
        idle_pct = 60;
        random_phase(22);
        write_revision(8'($urandom));
        idle_pct = 0;
        for (int i = 0; i < 3; i++) send_item(make_item(ACT_START, 8'(i), 0, 0, 0));
        for (int i = 0; i < 3; i++) send_item(make_item(ACT_STOP, 8'(i), 0, 0, 0));
        random_phase(22);
        write_revision(8'd1);
        random_phase(12);

        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("deadline_timer_queue_core verification clean");
        else $display("deadline_timer_queue_core verification failed");
        $finish;
    end
endmodule

>>> deadline_timer_queue_core.f
hdl/dtq_pkg.sv
hdl/dtq_cell.sv
hdl/deadline_timer_queue_core.sv
tb/tb.sv
